// ===== rtl/sswt_pkg.sv =====
package sswt_pkg;

    // Opcodes of an input item
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_EVAL = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ENABLE    = 3'd0;
    localparam logic [2:0] CFG_SCHED_LO  = 3'd1;
    localparam logic [2:0] CFG_SCHED_MID = 3'd2;
    localparam logic [2:0] CFG_SCHED_HI  = 3'd3;
    localparam logic [2:0] CFG_MAX_RUN   = 3'd4;

    // Schedule geometry, fixed by the register layout (64 + 64 + 16)
    localparam int SLOT_COUNT = 144;
    localparam int SLOT_W     = 8;

    localparam logic [7:0] MAX_RUN_RESET = 8'd145;

    typedef logic [SLOT_W-1:0] t_slot;

    // minute / 10 for a 6-bit minute (0..63)
    function automatic logic [2:0] div10(input logic [5:0] m);
        logic [2:0] d;
        if (m >= 6'd60) begin
            d = 3'd6;
        end else if (m >= 6'd50) begin
            d = 3'd5;
        end else if (m >= 6'd40) begin
            d = 3'd4;
        end else if (m >= 6'd30) begin
            d = 3'd3;
        end else if (m >= 6'd20) begin
            d = 3'd2;
        end else if (m >= 6'd10) begin
            d = 3'd1;
        end else begin
            d = 3'd0;
        end
        return d;
    endfunction

    // minute % 10
    function automatic logic [3:0] mod10(input logic [5:0] m);
        logic [5:0] d6;
        logic [5:0] r;
        d6 = {3'b000, div10(m)};
        r  = m - ((d6 << 3) + (d6 << 1));
        return r[3:0];
    endfunction

endpackage

// ===== rtl/slot_schedule_wake_timer_core.sv =====
// Slot-schedule wake timer.
// Input channel (i_in_valid / o_in_stall) carries one item: an opcode (tick one
// second, load time, re-evaluate the active flag) and the time fields used by
// a load. Output channel (o_out_valid / i_out_stall) returns one item per input
// item: active flag, seconds until the active run ends, capped run length and
// the clock (hour, minute, second, day count) after the update.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) writes
// enable, the three schedule words and the run-length cap; taken when idle.
// Operation: the 144-slot schedule lives in one rotating shift register that
// turns one slot per cycle; one full turn per item finds the current slot
// bit and the run of set slots after it. An accepted item passes through the
// states SLOT, SCAN, CALC1, CALC2 and DONE; no new item is taken before IDLE.
// The finished result sits in an output register, so the next item is
// accepted while it waits; a stalled receiver only holds the block at the
// end of the following item.
// Reset (synchronous, active low): clock 00:00:00 day 0, active set,
// enable set, schedule cleared, cap 145, both channels empty.
module slot_schedule_wake_timer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [4:0]  i_new_hour,
    input  logic [5:0]  i_new_minute,
    input  logic [5:0]  i_new_second,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_active,
    output logic [16:0] o_idle_seconds,
    output logic [7:0]  o_run_length,
    output logic [4:0]  o_hour_now,
    output logic [5:0]  o_minute_now,
    output logic [5:0]  o_second_now,
    output logic [15:0] o_day_count,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SLOT  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_CALC1 = 3'd3;
    localparam logic [2:0] ST_CALC2 = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam sswt_pkg::t_slot LAST_SLOT = sswt_pkg::t_slot'(sswt_pkg::SLOT_COUNT - 1);
    localparam sswt_pkg::t_slot SLOT_NUM  = sswt_pkg::t_slot'(sswt_pkg::SLOT_COUNT);

    logic [2:0] r_state, n_state;

    // config
    logic                              r_enable;
    logic [sswt_pkg::SLOT_COUNT-1:0]   r_sched;    // bit 0 is slot r_pos
    logic [7:0]                        r_max_run;

    // clock
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;
    logic [15:0] r_days, n_days;
    logic        r_active;
    logic [1:0]  r_op;

    // scan
    sswt_pkg::t_slot r_slot;
    sswt_pkg::t_slot r_pos;
    logic [3:0]      r_m10;
    logic            r_pre_run;
    sswt_pkg::t_slot r_pre_cnt;
    logic            r_tail_run;
    sswt_pkg::t_slot r_tail_cnt;
    logic            r_cur_bit;

    // arithmetic
    logic [10:0] r_span;       // 10*run + 9 - minute%10
    logic [8:0]  r_runlen_raw;
    logic [16:0] r_idle;
    logic [7:0]  r_runlen;

    // outputs
    logic        r_out_valid;
    logic        r_o_active;
    logic [16:0] r_o_idle;
    logic [7:0]  r_o_runlen;
    logic [4:0]  r_o_hour;
    logic [5:0]  r_o_minute;
    logic [5:0]  r_o_second;
    logic [15:0] r_o_days;

    logic in_acc;
    logic cfg_acc;
    logic out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;

    // clock update for an accepted item
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    always_comb begin
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_days   = r_days;
        sec_inc  = {1'b0, r_second} + 7'd1;
        min_inc  = {1'b0, r_minute};
        hour_inc = {1'b0, r_hour};
        case (i_opcode)
            sswt_pkg::OP_TICK: begin
                if (sec_inc >= 7'd60) begin
                    n_second = 6'd0;
                    min_inc  = {1'b0, r_minute} + 7'd1;
                end else begin
                    n_second = sec_inc[5:0];
                end
                if (min_inc >= 7'd60) begin
                    n_minute = 6'd0;
                    hour_inc = {1'b0, r_hour} + 6'd1;
                end else begin
                    n_minute = min_inc[5:0];
                end
                if (hour_inc >= 6'd24) begin
                    n_hour = 5'd0;
                    n_days = r_days + 16'd1;
                end else begin
                    n_hour = hour_inc[4:0];
                end
            end
            sswt_pkg::OP_LOAD: begin
                n_hour   = i_new_hour;
                n_minute = i_new_minute;
                n_second = i_new_second;
            end
            default: begin
            end
        endcase
    end

    // current slot = (hour*6 + minute/10) mod 144; sum stays below 2*144
    logic [7:0] slot_sum;
    assign slot_sum = ({3'b000, r_hour} << 2) + ({3'b000, r_hour} << 1)
                    + {5'b00000, sswt_pkg::div10(r_minute)};

    // run after the current slot, wrapping into the leading run of the day
    sswt_pkg::t_slot slot_p1;
    sswt_pkg::t_slot pre_lim;
    sswt_pkg::t_slot run;
    assign slot_p1 = r_slot + 8'd1;
    assign pre_lim = (r_pre_cnt < slot_p1) ? r_pre_cnt : slot_p1;
    assign run     = r_tail_run ? (r_tail_cnt + pre_lim) : r_tail_cnt;

    logic [16:0] idle_full;
    assign idle_full = ({6'd0, r_span} << 6) - ({6'd0, r_span} << 2) + 17'd60;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_SLOT;
            ST_SLOT:  n_state = ST_SCAN;
            ST_SCAN:  if (r_pos == LAST_SLOT) n_state = ST_CALC1;
            ST_CALC1: n_state = ST_CALC2;
            ST_CALC2: n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_enable    <= 1'b1;
            r_sched     <= '0;
            r_max_run   <= sswt_pkg::MAX_RUN_RESET;
            r_hour      <= '0;
            r_minute    <= '0;
            r_second    <= '0;
            r_days      <= '0;
            r_active    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                case (i_cfg_index)
                    sswt_pkg::CFG_ENABLE:    r_enable       <= i_cfg_data[0];
                    sswt_pkg::CFG_SCHED_LO:  r_sched[63:0]  <= i_cfg_data;
                    sswt_pkg::CFG_SCHED_MID: r_sched[127:64] <= i_cfg_data;
                    sswt_pkg::CFG_SCHED_HI:  r_sched[143:128] <= i_cfg_data[15:0];
                    sswt_pkg::CFG_MAX_RUN:   r_max_run      <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            // one full turn per item brings the schedule back in place
            if (r_state == ST_SCAN) begin
                r_sched <= {r_sched[0], r_sched[sswt_pkg::SLOT_COUNT-1:1]};
            end
            if (in_acc) begin
                r_hour   <= n_hour;
                r_minute <= n_minute;
                r_second <= n_second;
                r_days   <= n_days;
            end
            if (r_state == ST_CALC1 && r_op == sswt_pkg::OP_EVAL) begin
                r_active <= r_enable & r_cur_bit;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op <= i_opcode;
        end
        case (r_state)
            ST_SLOT: begin
                r_slot     <= (slot_sum >= SLOT_NUM) ? (slot_sum - SLOT_NUM) : slot_sum;
                r_m10      <= sswt_pkg::mod10(r_minute);
                r_pos      <= '0;
                r_pre_run  <= 1'b1;
                r_pre_cnt  <= '0;
                r_tail_run <= 1'b1;
                r_tail_cnt <= '0;
                r_cur_bit  <= 1'b0;
            end
            ST_SCAN: begin
                r_pos <= r_pos + 8'd1;
                if (r_pre_run) begin
                    if (r_sched[0]) begin
                        r_pre_cnt <= r_pre_cnt + 8'd1;
                    end else begin
                        r_pre_run <= 1'b0;
                    end
                end
                if (r_pos == r_slot) begin
                    r_cur_bit <= r_sched[0];
                end
                if (r_pos > r_slot && r_tail_run) begin
                    if (r_sched[0]) begin
                        r_tail_cnt <= r_tail_cnt + 8'd1;
                    end else begin
                        r_tail_run <= 1'b0;
                    end
                end
            end
            ST_CALC1: begin
                r_span <= ({3'b000, run} << 3) + ({3'b000, run} << 1) + 11'd9
                        - {7'd0, r_m10};
                r_runlen_raw <= {1'b0, run} + 9'd1;
            end
            ST_CALC2: begin
                if (!r_active || idle_full < {11'd0, r_second}) begin
                    r_idle <= '0;
                end else begin
                    r_idle <= idle_full - {11'd0, r_second};
                end
                if (!r_active) begin
                    r_runlen <= '0;
                end else if (r_runlen_raw > {1'b0, r_max_run}) begin
                    r_runlen <= r_max_run;
                end else begin
                    r_runlen <= r_runlen_raw[7:0];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_o_active <= r_active;
                    r_o_idle   <= r_idle;
                    r_o_runlen <= r_runlen;
                    r_o_hour   <= r_hour;
                    r_o_minute <= r_minute;
                    r_o_second <= r_second;
                    r_o_days   <= r_days;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_active       = r_o_active;
    assign o_idle_seconds = r_o_idle;
    assign o_run_length   = r_o_runlen;
    assign o_hour_now     = r_o_hour;
    assign o_minute_now   = r_o_minute;
    assign o_second_now   = r_o_second;
    assign o_day_count    = r_o_days;

endmodule

// ===== bench/tb.sv =====
module tb;

    // Opcode 3 has no meaning: state holds, a result still comes back
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    // Index with no register behind it; a write there must change nothing
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // The limit leaves several times the length of the slowest legal run, with
    // the largest gap and stall drawn for every item.
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 130;

    typedef struct {
        logic [1:0] op;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_timer_cmd;

    typedef struct {
        logic        active;
        logic [16:0] idle_s;
        logic [7:0]  run_len;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [15:0] days;
    } t_wake_status;

    // DUT connections; every input is known from time zero
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_opcode     = '0;
    logic [4:0]  i_new_hour   = '0;
    logic [5:0]  i_new_minute = '0;
    logic [5:0]  i_new_second = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic        o_active;
    logic [16:0] o_idle_seconds;
    logic [7:0]  o_run_length;
    logic [4:0]  o_hour_now;
    logic [5:0]  o_minute_now;
    logic [5:0]  o_second_now;
    logic [15:0] o_day_count;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index  = '0;
    logic [63:0] i_cfg_data   = '0;

    // Shadow of the timer: clock kept as plain ints so that out-of-range
    // loads carry exactly like the hardware's wider compare (63+1 is 64,
    // not 0).
    int           tod_hour   = 0;
    int           tod_minute = 0;
    int           tod_second = 0;
    int           tod_days   = 0;
    bit           awake      = 1'b1;
    bit           cfg_enable = 1'b1;
    logic [143:0] sched      = '0;   // slot k is bit k
    logic [7:0]   run_cap    = sswt_pkg::MAX_RUN_RESET;

    t_timer_cmd   cmd_q[$];          // items waiting for the driver
    t_wake_status status_q[$];       // predicted results, oldest first
    int           in_flight   = 0;   // queued items whose result is not back
    int           error_count = 0;
    int           cycle_count = 0;
    bit           calm        = 1'b0; // phase without any idling
    int           send_wait   = 0;
    int           recv_wait   = 0;
    logic         item_taken   = 1'b0;
    logic         result_taken = 1'b0;

    slot_schedule_wake_timer_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_new_hour     (i_new_hour),
        .i_new_minute   (i_new_minute),
        .i_new_second   (i_new_second),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_active       (o_active),
        .o_idle_seconds (o_idle_seconds),
        .o_run_length   (o_run_length),
        .o_hour_now     (o_hour_now),
        .o_minute_now   (o_minute_now),
        .o_second_now   (o_second_now),
        .o_day_count    (o_day_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int slot_of_now();
        return (tod_hour * 6 + tod_minute / 10) % sswt_pkg::SLOT_COUNT;
    endfunction

    // Apply one item to the shadow clock and return the status it yields
    function automatic t_wake_status advance_timer(input logic [1:0] op,
                                                   input logic [4:0] hh,
                                                   input logic [5:0] mm,
                                                   input logic [5:0] ss);
        t_wake_status st;
        int           slot;
        int           run;
        int           secs;
        case (op)
            sswt_pkg::OP_TICK: begin
                // each carry test runs on every tick, so bad loads heal
                tod_second++;
                if (tod_second >= 60) begin
                    tod_second = 0;
                    tod_minute++;
                end
                if (tod_minute >= 60) begin
                    tod_minute = 0;
                    tod_hour++;
                end
                if (tod_hour >= 24) begin
                    tod_hour = 0;
                    tod_days = (tod_days + 1) % 65536;
                end
            end
            sswt_pkg::OP_LOAD: begin
                tod_hour   = hh;
                tod_minute = mm;
                tod_second = ss;
            end
            sswt_pkg::OP_EVAL: awake = cfg_enable & sched[slot_of_now()];
            default: ;
        endcase

        st.active  = awake;
        st.idle_s  = '0;
        st.run_len = '0;
        if (awake) begin
            // count set slots after the current one, wrapping past slot 143;
            // a full schedule stops after one whole turn
            run  = 0;
            slot = (slot_of_now() + 1) % sswt_pkg::SLOT_COUNT;
            while (run < sswt_pkg::SLOT_COUNT && sched[slot]) begin
                run++;
                slot = (slot + 1) % sswt_pkg::SLOT_COUNT;
            end
            // a loaded second above 60 can push this below zero: clamp
            secs = (10 * run + 9 - tod_minute % 10) * 60 + (60 - tod_second);
            st.idle_s  = (secs < 0) ? 17'd0 : 17'(secs);
            st.run_len = (run + 1 > run_cap) ? run_cap : 8'(run + 1);
        end
        st.hour   = 5'(tod_hour);
        st.minute = 6'(tod_minute);
        st.second = 6'(tod_second);
        st.days   = 16'(tod_days);
        return st;
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [63:0] data);
        case (idx)
            sswt_pkg::CFG_ENABLE:    cfg_enable      = data[0];
            sswt_pkg::CFG_SCHED_LO:  sched[63:0]     = data;
            sswt_pkg::CFG_SCHED_MID: sched[127:64]   = data;
            sswt_pkg::CFG_SCHED_HI:  sched[143:128]  = data[15:0];
            sswt_pkg::CFG_MAX_RUN:   run_cap         = data[7:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            log_error($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Samples both channels at the rising edge. Predictions are made at the
    // edge that accepts the item, with the config as written so far.
    always @(posedge i_clk) begin : monitor
        t_wake_status want;
        if (!i_rst_n) begin
            item_taken   <= 1'b0;
            result_taken <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
            end
            item_taken   <= i_in_valid && !o_in_stall;
            result_taken <= o_out_valid && !i_out_stall;
            if (i_in_valid && !o_in_stall) begin
                status_q.push_back(advance_timer(i_opcode, i_new_hour,
                                                 i_new_minute, i_new_second));
            end
            if (o_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    log_error("result item with no item outstanding");
                end else begin
                    want = status_q.pop_front();
                    in_flight--;
                    compare_field("active", 32'(o_active), 32'(want.active));
                    compare_field("idle_seconds", 32'(o_idle_seconds),
                                  32'(want.idle_s));
                    compare_field("run_length", 32'(o_run_length),
                                  32'(want.run_len));
                    compare_field("hour_now", 32'(o_hour_now), 32'(want.hour));
                    compare_field("minute_now", 32'(o_minute_now),
                                  32'(want.minute));
                    compare_field("second_now", 32'(o_second_now),
                                  32'(want.second));
                    compare_field("day_count", 32'(o_day_count), 32'(want.days));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving (falling edge)
    // ------------------------------------------------------------------

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Sender: once the held item is taken, waits its drawn gap, then
    // presents the next one. Valid only drops when the item was taken.
    always @(negedge i_clk) begin : item_driver
        t_timer_cmd nxt;
        if (i_rst_n && (!i_in_valid || item_taken)) begin
            if (send_wait > 0) begin
                send_wait--;
                i_in_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                nxt = cmd_q.pop_front();
                i_in_valid   <= 1'b1;
                i_opcode     <= nxt.op;
                i_new_hour   <= nxt.hour;
                i_new_minute <= nxt.minute;
                i_new_second <= nxt.second;
                send_wait = draw_wait();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: each result is held off for a drawn number of cycles,
    // counted only while a result is actually offered.
    always @(negedge i_clk) begin : result_receiver
        if (result_taken) begin
            recv_wait = draw_wait();
        end
        i_out_stall <= (recv_wait > 0);
        if (o_out_valid && recv_wait > 0) begin
            recv_wait--;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_cmd(input logic [1:0] op, input logic [4:0] hh,
                             input logic [5:0] mm, input logic [5:0] ss);
        t_timer_cmd c;
        c.op     = op;
        c.hour   = hh;
        c.minute = mm;
        c.second = ss;
        cmd_q.push_back(c);
        in_flight++;
    endtask

    // Sender pause: nothing new until every queued item has its result
    task automatic wait_drained();
        while (in_flight != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mix of empty, full, random, dense and sparse slot patterns
    function automatic logic [63:0] random_sched_word();
        logic [63:0] w;
        case ($urandom_range(0, 5))
            0: w = '0;
            1: w = '1;
            2: w = {$urandom, $urandom};
            3: w = {$urandom, $urandom} | {$urandom, $urandom};
            4: w = {$urandom, $urandom} & {$urandom, $urandom};
            default: w = ~({$urandom, $urandom} & {$urandom, $urandom}
                           & {$urandom, $urandom});
        endcase
        return w;
    endfunction

    initial begin : stimulus
        int          phase;
        int          n;
        int          len;
        int          k;
        int          pick;
        logic [1:0]  op;
        logic [4:0]  hh;
        logic [5:0]  mm;
        logic [5:0]  ss;
        logic [63:0] word;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // reset state: active set, empty schedule; an unused opcode with every field at its top
        queue_cmd(sswt_pkg::OP_TICK, 5'd0, 6'd0, 6'd0);
        queue_cmd(OP_UNUSED, 5'd31, 6'd63, 6'd63);
        queue_cmd(sswt_pkg::OP_EVAL, 5'd0, 6'd0, 6'd0);
        wait_drained();

        // full schedule: run scan must stop after one whole turn
        write_reg(sswt_pkg::CFG_ENABLE, '1);
        write_reg(sswt_pkg::CFG_SCHED_LO, '1);
        write_reg(sswt_pkg::CFG_SCHED_MID, '1);
        write_reg(sswt_pkg::CFG_SCHED_HI, '1);
        write_reg(sswt_pkg::CFG_MAX_RUN, {56'hff_ffff_ffff_ffff, 8'd145});
        queue_cmd(sswt_pkg::OP_EVAL, 5'd0, 6'd0, 6'd0);
        queue_cmd(sswt_pkg::OP_LOAD, 5'd23, 6'd59, 6'd58);
        queue_cmd(sswt_pkg::OP_TICK, 5'd0, 6'd0, 6'd0);
        queue_cmd(sswt_pkg::OP_TICK, 5'd0, 6'd0, 6'd0);    // day rollover
        queue_cmd(sswt_pkg::OP_LOAD, 5'd31, 6'd63, 6'd63); // out of range load
        queue_cmd(sswt_pkg::OP_EVAL, 5'd0, 6'd0, 6'd0);    // slot index wraps
        queue_cmd(sswt_pkg::OP_TICK, 5'd0, 6'd0, 6'd0);    // all three carries
        queue_cmd(sswt_pkg::OP_LOAD, 5'd24, 6'd0, 6'd0);
        queue_cmd(sswt_pkg::OP_TICK, 5'd0, 6'd0, 6'd0);
        wait_drained();

        // slots 0 and 143 only, cap of zero
        write_reg(sswt_pkg::CFG_ENABLE, 64'd1);
        write_reg(sswt_pkg::CFG_SCHED_LO, 64'd1);
        write_reg(sswt_pkg::CFG_SCHED_MID, '0);
        write_reg(sswt_pkg::CFG_SCHED_HI, 64'h8000);
        write_reg(sswt_pkg::CFG_MAX_RUN, 64'd0);
        queue_cmd(sswt_pkg::OP_LOAD, 5'd0, 6'd9, 6'd63);
        queue_cmd(sswt_pkg::OP_EVAL, 5'd0, 6'd0, 6'd0);    // idle time clamps to 0
        queue_cmd(sswt_pkg::OP_TICK, 5'd0, 6'd0, 6'd0);
        queue_cmd(sswt_pkg::OP_EVAL, 5'd0, 6'd0, 6'd0);
        queue_cmd(sswt_pkg::OP_LOAD, 5'd23, 6'd55, 6'd0);
        queue_cmd(sswt_pkg::OP_EVAL, 5'd0, 6'd0, 6'd0);    // run wraps into slot 0
        wait_drained();

        write_reg(sswt_pkg::CFG_MAX_RUN, 64'd1);
        write_reg(sswt_pkg::CFG_ENABLE, ~64'd1);           // enable off
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        queue_cmd(sswt_pkg::OP_EVAL, 5'd0, 6'd0, 6'd0);
        queue_cmd(sswt_pkg::OP_LOAD, 5'd0, 6'd0, 6'd0);
        wait_drained();

        write_reg(sswt_pkg::CFG_MAX_RUN, 64'd255);
        write_reg(sswt_pkg::CFG_ENABLE, 64'd1);
        queue_cmd(sswt_pkg::OP_EVAL, 5'd0, 6'd0, 6'd0);
        queue_cmd(sswt_pkg::OP_TICK, 5'd0, 6'd0, 6'd0);

        // --- random phases ---
        // Each phase waits for the block to drain, rewrites all registers,
        // then runs episodes: a time load (often near a slot or day edge)
        // followed by a burst of ticks and re-evaluations with some noise.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            calm = (phase % 4 == 1);

            word = {$urandom, $urandom};
            word[0] = ($urandom_range(0, 3) != 0);
            write_reg(sswt_pkg::CFG_ENABLE, word);
            write_reg(sswt_pkg::CFG_SCHED_LO, random_sched_word());
            write_reg(sswt_pkg::CFG_SCHED_MID, random_sched_word());
            write_reg(sswt_pkg::CFG_SCHED_HI, random_sched_word());
            word = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: word[7:0] = 8'd0;
                1: word[7:0] = 8'd145;
                2: word[7:0] = 8'd255;
                3: word[7:0] = 8'd1;
                default: word[7:0] = 8'($urandom_range(1, 145));
            endcase
            write_reg(sswt_pkg::CFG_MAX_RUN, word);

            n = 0;
            while (n < PHASE_ITEMS) begin
                case ($urandom_range(0, 4))
                    0: begin
                        hh = 5'($urandom);
                        mm = 6'($urandom);
                        ss = 6'($urandom);
                    end
                    1: begin
                        hh = 5'd23;
                        mm = 6'd59;
                        ss = 6'($urandom_range(40, 59));
                    end
                    2: begin
                        hh = 5'($urandom_range(0, 23));
                        mm = 6'(10 * $urandom_range(0, 5) + 9);
                        ss = 6'($urandom_range(40, 63));
                    end
                    default: begin
                        hh = 5'($urandom_range(0, 23));
                        mm = 6'($urandom_range(0, 59));
                        ss = 6'($urandom_range(0, 59));
                    end
                endcase
                queue_cmd(sswt_pkg::OP_LOAD, hh, mm, ss);
                len = $urandom_range(4, 24);
                for (k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60) begin
                        op = sswt_pkg::OP_TICK;
                    end else if (pick < 88) begin
                        op = sswt_pkg::OP_EVAL;
                    end else if (pick < 95) begin
                        op = sswt_pkg::OP_LOAD;
                    end else begin
                        op = OP_UNUSED;
                    end
                    queue_cmd(op, 5'($urandom), 6'($urandom), 6'($urandom));
                end
                n += len + 1;
            end
        end

        // --- wrap up ---
        wait_drained();
        repeat (160) @(negedge i_clk);
        if (status_q.size() != 0) begin
            log_error($sformatf("%0d expected results never arrived", status_q.size()));
        end
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sswt_pkg.sv
rtl/slot_schedule_wake_timer_core.sv
bench/tb.sv
